@@ sv/rvid_pkg.sv @@
// Shared types and constants for the RV32IM instruction decoder.
package rvid_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned CodeW = 6;
  localparam int unsigned RegW  = 5;
  localparam int unsigned ImmW  = 21;

  localparam logic [6:0] OP_REG    = 7'h33;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_AUIPC  = 7'h17;
  localparam logic [6:0] OP_JAL    = 7'h6F;
  localparam logic [6:0] OP_SYSTEM = 7'h73;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_MEXT = 7'h01;
  localparam logic [6:0] F7_ALT  = 7'h20;

  typedef enum logic [CodeW-1:0] {
    MN_ADD   = 6'd0,  MN_MUL   = 6'd1,  MN_SUB   = 6'd2,  MN_SLL   = 6'd3,
    MN_MULH  = 6'd4,  MN_SLT   = 6'd5,  MN_SLTU  = 6'd6,  MN_MULHU = 6'd7,
    MN_XOR   = 6'd8,  MN_DIV   = 6'd9,  MN_SRL   = 6'd10, MN_DIVU  = 6'd11,
    MN_SRA   = 6'd12, MN_OR    = 6'd13, MN_REM   = 6'd14, MN_AND   = 6'd15,
    MN_REMU  = 6'd16, MN_ADDI  = 6'd17, MN_SLLI  = 6'd18, MN_SLTI  = 6'd19,
    MN_SLTIU = 6'd20, MN_XORI  = 6'd21, MN_SRLI  = 6'd22, MN_SRAI  = 6'd23,
    MN_ORI   = 6'd24, MN_ANDI  = 6'd25, MN_LB    = 6'd26, MN_LH    = 6'd27,
    MN_LW    = 6'd28, MN_LBU   = 6'd29, MN_LHU   = 6'd30, MN_SB    = 6'd31,
    MN_SH    = 6'd32, MN_SW    = 6'd33, MN_BEQ   = 6'd34, MN_BNE   = 6'd35,
    MN_BLT   = 6'd36, MN_BGE   = 6'd37, MN_BLTU  = 6'd38, MN_BGEU  = 6'd39,
    MN_JALR  = 6'd40, MN_LUI   = 6'd41, MN_AUIPC = 6'd42, MN_JAL   = 6'd43,
    MN_ECALL = 6'd44
  } mnemonic_t;

endpackage

@@ sv/rvid_if.sv @@
// Valid/ready channels for instruction words and decoded results.
interface rvid_instr_if;
  logic                        valid;
  logic                        ready;
  logic [rvid_pkg::WordW-1:0]  instruction_word;

  modport source (output valid, output instruction_word, input ready);
  modport sink   (input valid, input instruction_word, output ready);
endinterface

interface rvid_result_if;
  logic                              valid;
  logic                              ready;
  logic [rvid_pkg::CodeW-1:0]        mnemonic_code;
  logic [rvid_pkg::RegW-1:0]         dest_reg;
  logic [rvid_pkg::RegW-1:0]         src1_reg;
  logic [rvid_pkg::RegW-1:0]         src2_reg;
  logic signed [rvid_pkg::ImmW-1:0]  immediate;
  logic                              invalid;

  modport source (output valid, output mnemonic_code, output dest_reg, output src1_reg,
                  output src2_reg, output immediate, output invalid, input ready);
  modport sink   (input valid, input mnemonic_code, input dest_reg, input src1_reg,
                  input src2_reg, input immediate, input invalid, output ready);
endinterface

@@ sv/rv32im_instruction_decoder_unit.sv @@
// RV32IM instruction decoder: input register, decode logic, result register.
//
// Channels: instr carries one 32-bit instruction word per transfer; result
// carries the mnemonic code, rd/rs1/rs2, the signed 21-bit immediate and an
// invalid flag. Both are valid/ready; a transfer happens when both are high.
// Unknown encodings come out with invalid set and every other field zero.
// Path: a taken word is held in the input register, decoded combinationally
// and offered on result once it has moved into the result register.
// Throughput: one word per cycle, set by the two register stages that each
// advance every cycle the stage after them is empty or being drained.
// Stall: while result.ready is low a full result register holds; an empty
// input register still takes one more word, then instr.ready drops until the
// result is taken.
// Reset (rst, synchronous): both stages are emptied; no result is offered
// and instr.ready is high on the first cycle after reset.
module rv32im_instruction_decoder_unit (
  input  logic                 clk,
  input  logic                 rst,
  rvid_instr_if.sink           instr,
  rvid_result_if.source        result
);
  import rvid_pkg::*;

  logic              in_valid;
  logic [WordW-1:0]  word;
  logic              out_valid;
  logic              in_adv;

  logic [CodeW-1:0]        mnemonic_code;
  logic [RegW-1:0]         dest_reg;
  logic [RegW-1:0]         src1_reg;
  logic [RegW-1:0]         src2_reg;
  logic signed [ImmW-1:0]  immediate;
  logic                    invalid;

  mnemonic_t               code_next;
  logic [RegW-1:0]         dest_reg_next;
  logic [RegW-1:0]         src1_reg_next;
  logic [RegW-1:0]         src2_reg_next;
  logic signed [ImmW-1:0]  immediate_next;
  logic                    invalid_next;

  logic [6:0]  opcode;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [RegW-1:0] rd, rs1, rs2;
  logic [ImmW-1:0] imm_i, imm_s, imm_b, imm_j, imm_u, imm_sh;
  mnemonic_t   code;
  logic        bad;
  logic        uses_rd, uses_rs1, uses_rs2;
  logic [ImmW-1:0] imm;

  assign in_adv      = !out_valid || result.ready;
  assign instr.ready = !in_valid || in_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (instr.ready) begin
      in_valid <= instr.valid;
    end
    if (instr.valid && instr.ready) begin
      word <= instr.instruction_word;
    end
  end

  assign opcode = word[6:0];
  assign rd     = word[11:7];
  assign f3     = word[14:12];
  assign rs1    = word[19:15];
  assign rs2    = word[24:20];
  assign f7     = word[31:25];

  assign imm_i  = {{9{word[31]}}, word[31:20]};
  assign imm_s  = {{9{word[31]}}, word[31:25], word[11:7]};
  assign imm_b  = {{8{word[31]}}, word[31], word[7], word[30:25], word[11:8], 1'b0};
  assign imm_j  = {word[31], word[19:12], word[20], word[30:21], 1'b0};
  assign imm_u  = {1'b0, word[31:12]};
  assign imm_sh = {16'd0, word[24:20]};

  always_comb begin
    code     = MN_ADD;
    bad      = 1'b0;
    uses_rd  = 1'b0;
    uses_rs1 = 1'b0;
    uses_rs2 = 1'b0;
    imm      = '0;
    unique case (opcode)
      OP_REG: begin
        uses_rd  = 1'b1;
        uses_rs1 = 1'b1;
        uses_rs2 = 1'b1;
        if (f3 == 3'd2) begin
          code = MN_SLT;
        end else if (f7 == F7_BASE) begin
          unique case (f3)
            3'd0:    code = MN_ADD;
            3'd1:    code = MN_SLL;
            3'd3:    code = MN_SLTU;
            3'd4:    code = MN_XOR;
            3'd5:    code = MN_SRL;
            3'd6:    code = MN_OR;
            3'd7:    code = MN_AND;
            default: code = MN_SLT;
          endcase
        end else if (f7 == F7_MEXT) begin
          unique case (f3)
            3'd0:    code = MN_MUL;
            3'd1:    code = MN_MULH;
            3'd3:    code = MN_MULHU;
            3'd4:    code = MN_DIV;
            3'd5:    code = MN_DIVU;
            3'd6:    code = MN_REM;
            3'd7:    code = MN_REMU;
            default: code = MN_SLT;
          endcase
        end else if (f7 == F7_ALT && f3 == 3'd0) begin
          code = MN_SUB;
        end else if (f7 == F7_ALT && f3 == 3'd5) begin
          code = MN_SRA;
        end else begin
          bad = 1'b1;
        end
      end
      OP_IMM: begin
        uses_rd  = 1'b1;
        uses_rs1 = 1'b1;
        imm      = imm_i;
        unique case (f3)
          3'd0:    code = MN_ADDI;
          3'd1:    code = MN_SLLI;
          3'd2:    code = MN_SLTI;
          3'd3:    code = MN_SLTIU;
          3'd4:    code = MN_XORI;
          3'd5: begin
            if (word[30]) begin
              code = MN_SRAI;
              imm  = imm_sh;
            end else begin
              code = MN_SRLI;
            end
          end
          3'd6:    code = MN_ORI;
          default: code = MN_ANDI;
        endcase
      end
      OP_LOAD: begin
        uses_rd  = 1'b1;
        uses_rs1 = 1'b1;
        imm      = imm_i;
        unique case (f3)
          3'd0:    code = MN_LB;
          3'd1:    code = MN_LH;
          3'd2:    code = MN_LW;
          3'd4:    code = MN_LBU;
          3'd5:    code = MN_LHU;
          default: bad  = 1'b1;
        endcase
      end
      OP_JALR: begin
        code     = MN_JALR;
        uses_rd  = 1'b1;
        uses_rs1 = 1'b1;
        imm      = imm_i;
      end
      OP_STORE: begin
        uses_rs1 = 1'b1;
        uses_rs2 = 1'b1;
        imm      = imm_s;
        unique case (f3)
          3'd0:    code = MN_SB;
          3'd1:    code = MN_SH;
          3'd2:    code = MN_SW;
          default: bad  = 1'b1;
        endcase
      end
      OP_BRANCH: begin
        uses_rs1 = 1'b1;
        uses_rs2 = 1'b1;
        imm      = imm_b;
        unique case (f3)
          3'd0:    code = MN_BEQ;
          3'd1:    code = MN_BNE;
          3'd4:    code = MN_BLT;
          3'd5:    code = MN_BGE;
          3'd6:    code = MN_BLTU;
          3'd7:    code = MN_BGEU;
          default: bad  = 1'b1;
        endcase
      end
      OP_LUI: begin
        code    = MN_LUI;
        uses_rd = 1'b1;
        imm     = imm_u;
      end
      OP_AUIPC: begin
        code    = MN_AUIPC;
        uses_rd = 1'b1;
        imm     = imm_u;
      end
      OP_JAL: begin
        code    = MN_JAL;
        uses_rd = 1'b1;
        imm     = imm_j;
      end
      OP_SYSTEM: code = MN_ECALL;
      default:   bad  = 1'b1;
    endcase
  end

  // Unrecognized encodings report zeros in every field but the flag.
  always_comb begin
    invalid_next   = bad;
    code_next      = bad ? MN_ADD : code;
    dest_reg_next  = (uses_rd  && !bad) ? rd  : '0;
    src1_reg_next  = (uses_rs1 && !bad) ? rs1 : '0;
    src2_reg_next  = (uses_rs2 && !bad) ? rs2 : '0;
    immediate_next = bad ? '0 : imm;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_adv) begin
      out_valid <= in_valid;
    end
    if (in_valid && in_adv) begin
      mnemonic_code <= code_next;
      dest_reg      <= dest_reg_next;
      src1_reg      <= src1_reg_next;
      src2_reg      <= src2_reg_next;
      immediate     <= immediate_next;
      invalid       <= invalid_next;
    end
  end

  assign result.valid         = out_valid;
  assign result.mnemonic_code = mnemonic_code;
  assign result.dest_reg      = dest_reg;
  assign result.src1_reg      = src1_reg;
  assign result.src2_reg      = src2_reg;
  assign result.immediate     = immediate;
  assign result.invalid       = invalid;

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && invalid |-> mnemonic_code == MN_ADD && dest_reg == '0 &&
      src1_reg == '0 && src2_reg == '0 && immediate == '0)
    else $error("invalid result carries nonzero fields");

  a_code_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> mnemonic_code <= MN_ECALL)
    else $error("mnemonic code out of range");

  a_in_to_out: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_adv |=> out_valid)
    else $error("decoded word did not reach result register");

  a_take_fills: assert property (@(posedge clk) disable iff (rst)
    instr.valid && instr.ready |=> in_valid)
    else $error("accepted word lost from input register");

  a_hold_word: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_adv |=> in_valid && $stable(word))
    else $error("stalled input register changed");

endmodule

@@ sim/rv32im_instruction_decoder_unit_tb.sv @@
// Self-checking testbench for the RV32IM instruction decoder unit.
module rv32im_instruction_decoder_unit_tb;
  import rvid_pkg::*;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned RandWords  = 1900;

  typedef struct packed {
    mnemonic_t          code;
    logic [RegW-1:0]    rd;
    logic [RegW-1:0]    rs1;
    logic [RegW-1:0]    rs2;
    logic signed [ImmW-1:0] imm;
    logic               inv;
  } decoded_t;

  typedef struct packed {
    logic [WordW-1:0] word;
    decoded_t         exp;
  } xfer_t;

  typedef struct packed {
    logic [WordW-1:0] word;
    logic             typed;
    decoded_t         exp;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rvid_instr_if  instr_ch ();
  rvid_result_if result_ch ();

  rv32im_instruction_decoder_unit u_dut (
    .clk    (clk),
    .rst    (rst),
    .instr  (instr_ch),
    .result (result_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  xfer_t       word_q[$];
  decoded_t    pending_decodes[$];
  stim_row_t   dir_table[$];
  xfer_t       cur_xfer;
  decoded_t    cur_exp;
  logic        word_taken = 1'b0;
  logic        res_taken  = 1'b0;
  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  int unsigned stall_cycles = 0;
  int unsigned errors       = 0;
  int unsigned n_checked    = 0;
  int unsigned n_invalid    = 0;
  int unsigned n_random     = 0;
  bit [44:0]   mn_seen      = '0;

  function automatic decoded_t decode_word(input logic [WordW-1:0] w);
    decoded_t    d;
    logic [6:0]  op;
    logic [6:0]  f7;
    logic [2:0]  f3;
    logic [11:0] iimm;
    logic        ok;
    op   = w[6:0];
    f3   = w[14:12];
    f7   = w[31:25];
    iimm = w[31:20];
    d    = '0;
    ok   = 1'b1;
    case (op)
      OP_REG: begin
        d.rd  = w[11:7];
        d.rs1 = w[19:15];
        d.rs2 = w[24:20];
        if (f3 == 3'd2) begin
          d.code = MN_SLT;
        end else if (f7 == F7_BASE) begin
          case (f3)
            3'd0:    d.code = MN_ADD;
            3'd1:    d.code = MN_SLL;
            3'd3:    d.code = MN_SLTU;
            3'd4:    d.code = MN_XOR;
            3'd5:    d.code = MN_SRL;
            3'd6:    d.code = MN_OR;
            default: d.code = MN_AND;
          endcase
        end else if (f7 == F7_MEXT) begin
          case (f3)
            3'd0:    d.code = MN_MUL;
            3'd1:    d.code = MN_MULH;
            3'd3:    d.code = MN_MULHU;
            3'd4:    d.code = MN_DIV;
            3'd5:    d.code = MN_DIVU;
            3'd6:    d.code = MN_REM;
            default: d.code = MN_REMU;
          endcase
        end else if (f7 == F7_ALT && f3 == 3'd0) begin
          d.code = MN_SUB;
        end else if (f7 == F7_ALT && f3 == 3'd5) begin
          d.code = MN_SRA;
        end else begin
          ok = 1'b0;
        end
      end
      OP_IMM: begin
        d.rd  = w[11:7];
        d.rs1 = w[19:15];
        d.imm = {{9{iimm[11]}}, iimm};
        case (f3)
          3'd0:    d.code = MN_ADDI;
          3'd1:    d.code = MN_SLLI;
          3'd2:    d.code = MN_SLTI;
          3'd3:    d.code = MN_SLTIU;
          3'd4:    d.code = MN_XORI;
          3'd5:    d.code = MN_SRLI;
          3'd6:    d.code = MN_ORI;
          default: d.code = MN_ANDI;
        endcase
        // arithmetic shift picked by bit 30 only; shamt kept, rest dropped
        if (f3 == 3'd5 && iimm[10]) begin
          d.code = MN_SRAI;
          d.imm  = {16'd0, iimm[4:0]};
        end
      end
      OP_LOAD: begin
        d.rd  = w[11:7];
        d.rs1 = w[19:15];
        d.imm = {{9{iimm[11]}}, iimm};
        case (f3)
          3'd0:    d.code = MN_LB;
          3'd1:    d.code = MN_LH;
          3'd2:    d.code = MN_LW;
          3'd4:    d.code = MN_LBU;
          3'd5:    d.code = MN_LHU;
          default: ok = 1'b0;
        endcase
      end
      OP_JALR: begin
        d.code = MN_JALR;
        d.rd   = w[11:7];
        d.rs1  = w[19:15];
        d.imm  = {{9{iimm[11]}}, iimm};
      end
      OP_STORE: begin
        d.rs1 = w[19:15];
        d.rs2 = w[24:20];
        d.imm = {{9{w[31]}}, w[31:25], w[11:7]};
        case (f3)
          3'd0:    d.code = MN_SB;
          3'd1:    d.code = MN_SH;
          3'd2:    d.code = MN_SW;
          default: ok = 1'b0;
        endcase
      end
      OP_BRANCH: begin
        d.rs1 = w[19:15];
        d.rs2 = w[24:20];
        d.imm = {{8{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
        case (f3)
          3'd0:    d.code = MN_BEQ;
          3'd1:    d.code = MN_BNE;
          3'd4:    d.code = MN_BLT;
          3'd5:    d.code = MN_BGE;
          3'd6:    d.code = MN_BLTU;
          3'd7:    d.code = MN_BGEU;
          default: ok = 1'b0;
        endcase
      end
      OP_LUI, OP_AUIPC: begin
        d.code = (op == OP_LUI) ? MN_LUI : MN_AUIPC;
        d.rd   = w[11:7];
        d.imm  = {1'b0, w[31:12]};
      end
      OP_JAL: begin
        d.code = MN_JAL;
        d.rd   = w[11:7];
        d.imm  = {w[31], w[19:12], w[20], w[30:21], 1'b0};
      end
      OP_SYSTEM: begin
        d.code = MN_ECALL;
      end
      default: ok = 1'b0;
    endcase
    if (!ok) begin
      d     = '0;
      d.inv = 1'b1;
    end
    return d;
  endfunction

  function automatic decoded_t mk(input mnemonic_t c, input logic [RegW-1:0] rd,
                                  input logic [RegW-1:0] rs1, input logic [RegW-1:0] rs2,
                                  input logic signed [ImmW-1:0] imm, input logic inv);
    decoded_t d;
    d.code = c;
    d.rd   = rd;
    d.rs1  = rs1;
    d.rs2  = rs2;
    d.imm  = imm;
    d.inv  = inv;
    return d;
  endfunction

  function automatic stim_row_t row(input logic [WordW-1:0] w, input logic typed,
                                    input decoded_t e);
    stim_row_t r;
    r.word  = w;
    r.typed = typed;
    r.exp   = e;
    return r;
  endfunction

  // mostly well-formed words of every opcode class with random fields; some noise
  function automatic logic [WordW-1:0] gen_word();
    logic [WordW-1:0] w;
    w = $urandom;
    if ($urandom_range(9) == 0) return w;
    case ($urandom_range(9))
      0: begin
        w[6:0] = OP_REG;
        case ($urandom_range(3))
          0:       w[31:25] = F7_BASE;
          1:       w[31:25] = F7_MEXT;
          2:       w[31:25] = F7_ALT;
          default: w[31:25] = w[31:25];
        endcase
      end
      1: w[6:0] = OP_IMM;
      2: w[6:0] = OP_LOAD;
      3: w[6:0] = OP_JALR;
      4: begin
        w[6:0] = OP_STORE;
        if ($urandom_range(4) != 0) w[14:12] = 3'($urandom_range(2));
      end
      5: w[6:0] = OP_BRANCH;
      6: w[6:0] = OP_LUI;
      7: w[6:0] = OP_AUIPC;
      8: w[6:0] = OP_JAL;
      default: w[6:0] = OP_SYSTEM;
    endcase
    return w;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  task automatic wait_for_drain();
    while (word_q.size() != 0 || instr_ch.valid || pending_decodes.size() != 0)
      @(posedge clk);
  endtask

  // sender and receiver, both driven on the falling edge
  always @(negedge clk) begin
    if (!instr_ch.valid || word_taken) begin
      if (word_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        cur_xfer = word_q.pop_front();
        instr_ch.valid            <= 1'b1;
        instr_ch.instruction_word <= cur_xfer.word;
        cur_exp                   <= cur_xfer.exp;
      end else begin
        instr_ch.valid            <= 1'b0;
        instr_ch.instruction_word <= $urandom;
      end
    end
    result_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // transfer monitor and result checker
  always @(posedge clk) begin
    word_taken = !rst && instr_ch.valid && instr_ch.ready;
    res_taken  = !rst && result_ch.valid && result_ch.ready;
    if (res_taken) begin
      if (pending_decodes.size() == 0) begin
        $display("%0t: result with nothing expected, code %0d", $time,
                 result_ch.mnemonic_code);
        errors++;
      end else begin
        decoded_t e;
        e = pending_decodes.pop_front();
        compare_field("mnemonic_code", 32'(e.code), 32'(result_ch.mnemonic_code));
        compare_field("dest_reg", 32'(e.rd), 32'(result_ch.dest_reg));
        compare_field("src1_reg", 32'(e.rs1), 32'(result_ch.src1_reg));
        compare_field("src2_reg", 32'(e.rs2), 32'(result_ch.src2_reg));
        compare_field("immediate", 32'(e.imm), 32'(result_ch.immediate));
        compare_field("invalid", 32'(e.inv), 32'(result_ch.invalid));
        n_checked++;
      end
    end
    if (word_taken) begin
      pending_decodes.push_back(cur_exp);
      if (cur_exp.inv) n_invalid++;
      else mn_seen[cur_exp.code] = 1'b1;
    end
    if (word_taken || res_taken) stall_cycles = 0;
    else stall_cycles++;
  end

  initial begin
    while (stall_cycles < StallLimit) @(posedge clk);
    $display("%0t: watchdog, no transfer for %0d cycles", $time, StallLimit);
    $display("simulation failed");
    $finish;
  end

  initial begin
    decoded_t    bad;
    xfer_t       x;
    int unsigned n;
    int unsigned src_pct[3];
    int unsigned snk_pct[3];
    instr_ch.valid            = 1'b0;
    instr_ch.instruction_word = '0;
    result_ch.ready           = 1'b0;
    bad = mk(MN_ADD, 5'd0, 5'd0, 5'd0, 21'sd0, 1'b1);
    src_pct = '{37, 63, 0};
    snk_pct = '{63, 37, 0};

    dir_table.push_back(row(32'h0000_0000, 1'b1, bad));
    dir_table.push_back(row(32'hFFFF_FFFF, 1'b1, bad));
    dir_table.push_back(row(32'hFFFF_FFF3, 1'b1,
                            mk(MN_ECALL, 5'd0, 5'd0, 5'd0, 21'sd0, 1'b0)));
    dir_table.push_back(row({25'd0, OP_SYSTEM}, 1'b1,
                            mk(MN_ECALL, 5'd0, 5'd0, 5'd0, 21'sd0, 1'b0)));
    dir_table.push_back(row(32'hFFFF_F037, 1'b1,
                            mk(MN_LUI, 5'd0, 5'd0, 5'd0, 21'h0FFFFF, 1'b0)));
    dir_table.push_back(row(32'hFFFF_FF97, 1'b1,
                            mk(MN_AUIPC, 5'd31, 5'd0, 5'd0, 21'h0FFFFF, 1'b0)));
    dir_table.push_back(row(32'hFFFF_FFEF, 1'b1,
                            mk(MN_JAL, 5'd31, 5'd0, 5'd0, -21'sd2, 1'b0)));
    dir_table.push_back(row({25'd0, OP_JAL}, 1'b0, '0));
    dir_table.push_back(row({7'h7F, 5'd31, 5'd31, 3'd2, 5'd31, OP_REG}, 1'b0, '0));
    dir_table.push_back(row({F7_MEXT, 5'd1, 5'd2, 3'd2, 5'd3, OP_REG}, 1'b0, '0));
    dir_table.push_back(row({F7_ALT, 5'd31, 5'd0, 3'd1, 5'd31, OP_REG}, 1'b1, bad));
    dir_table.push_back(row({7'h7F, 5'd5, 5'd6, 3'd0, 5'd7, OP_REG}, 1'b1, bad));
    dir_table.push_back(row({F7_ALT, 5'd9, 5'd10, 3'd0, 5'd11, OP_REG}, 1'b0, '0));
    dir_table.push_back(row({7'h7F, 5'd31, 5'd31, 3'd5, 5'd31, OP_IMM}, 1'b0, '0));
    dir_table.push_back(row({7'b1011111, 5'd31, 5'd1, 3'd5, 5'd2, OP_IMM}, 1'b0, '0));
    dir_table.push_back(row({7'b1011111, 5'd17, 5'd4, 3'd1, 5'd8, OP_IMM}, 1'b0, '0));
    dir_table.push_back(row({12'h800, 5'd0, 3'd0, 5'd0, OP_IMM}, 1'b1,
                            mk(MN_ADDI, 5'd0, 5'd0, 5'd0, -21'sd2048, 1'b0)));
    dir_table.push_back(row({12'h7FF, 5'd31, 3'd0, 5'd31, OP_IMM}, 1'b1,
                            mk(MN_ADDI, 5'd31, 5'd31, 5'd0, 21'sd2047, 1'b0)));
    dir_table.push_back(row({12'hFFF, 5'd31, 3'd3, 5'd31, OP_LOAD}, 1'b1, bad));
    dir_table.push_back(row({12'hFFF, 5'd31, 3'd2, 5'd31, OP_LOAD}, 1'b0, '0));
    dir_table.push_back(row({12'h800, 5'd9, 3'd7, 5'd10, OP_JALR}, 1'b0, '0));
    dir_table.push_back(row({7'h7F, 5'd31, 5'd31, 3'd3, 5'd31, OP_STORE}, 1'b1, bad));
    dir_table.push_back(row({7'h7F, 5'd31, 5'd31, 3'd2, 5'd31, OP_STORE}, 1'b1,
                            mk(MN_SW, 5'd0, 5'd31, 5'd31, -21'sd1, 1'b0)));
    dir_table.push_back(row({7'h7F, 5'd31, 5'd31, 3'd2, 5'd31, OP_BRANCH}, 1'b1, bad));
    dir_table.push_back(row({7'h3F, 5'd1, 5'd2, 3'd7, 5'd31, OP_BRANCH}, 1'b1,
                            mk(MN_BGEU, 5'd0, 5'd2, 5'd1, 21'sd4094, 1'b0)));
    dir_table.push_back(row({7'h40, 5'd0, 5'd0, 3'd0, 5'd0, OP_BRANCH}, 1'b1,
                            mk(MN_BEQ, 5'd0, 5'd0, 5'd0, -21'sd4096, 1'b0)));

    src_idle_pct = src_pct[0];
    snk_idle_pct = snk_pct[0];
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    foreach (dir_table[i]) begin
      x.word = dir_table[i].word;
      x.exp  = dir_table[i].typed ? dir_table[i].exp : decode_word(dir_table[i].word);
      word_q.push_back(x);
    end
    wait_for_drain();

    for (int ph = 0; ph < 3; ph++) begin
      src_idle_pct = src_pct[ph];
      snk_idle_pct = snk_pct[ph];
      n = (ph == 2) ? RandWords - 2 * (RandWords / 3) : RandWords / 3;
      for (int unsigned k = 0; k < n; k++) begin
        x.word = gen_word();
        x.exp  = decode_word(x.word);
        word_q.push_back(x);
        n_random++;
        // in the first phase only, queuing holds off midway until the decoder has emptied
        if (ph == 0 && k == n / 2) wait_for_drain();
      end
      wait_for_drain();
    end

    repeat (8) @(posedge clk);

    $display("ran %0d directed and %0d random words, %0d results checked",
             dir_table.size(), n_random, n_checked);
    $display("invalid encodings %0d, mnemonics hit %0d of 45", n_invalid,
             $countones(mn_seen));
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/rvid_pkg.sv
sv/rvid_if.sv
sv/rv32im_instruction_decoder_unit.sv
sim/rv32im_instruction_decoder_unit_tb.sv
